// File: hdl/presence_confirm_debouncer_top_assert.svh
// Assertion macros for the presence debouncer.
// Each expects clk_i and rst_ni in scope.
`ifndef PRESENCE_CONFIRM_DEBOUNCER_TOP_ASSERT_SVH
`define PRESENCE_CONFIRM_DEBOUNCER_TOP_ASSERT_SVH

// Same-cycle implication.
`define PCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pcd_pkg.sv
`default_nettype none

package pcd_pkg;

  localparam int unsigned TIME_FIELD_W = 40;
  localparam int unsigned WIN_W        = 27;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned APB_ADDR_W   = 3;

  localparam logic [WIN_W-1:0] ARRIVE_RESET = WIN_W'(3000);
  localparam logic [WIN_W-1:0] LEAVE_RESET  = WIN_W'(5 * 60 * 1000);

  typedef enum logic [KIND_W-1:0] {
    EV_DEPART       = 2'd0,
    EV_FIRST_ARRIVE = 2'd1,
    EV_ARRIVE       = 2'd2
  } event_kind_e;

  typedef enum logic [0:0] {
    REG_ARRIVE = 1'b0,
    REG_LEAVE  = 1'b1
  } cfg_reg_e;

endpackage

`default_nettype wire

// File: hdl/pcd_if.sv
`default_nettype none

interface pcd_sample_if;
  import pcd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    sample_valid;
  logic                    present;
  logic [TIME_FIELD_W-1:0] time_ms;

  modport source (output valid, sample_valid, present, time_ms, input ready);
  modport sink   (input valid, sample_valid, present, time_ms, output ready);
endinterface

interface pcd_event_if;
  import pcd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       event_kind;
  logic [TIME_FIELD_W-1:0] span_ms;

  modport source (output valid, event_kind, span_ms, input ready);
  modport sink   (input valid, event_kind, span_ms, output ready);
endinterface

`default_nettype wire

// File: hdl/presence_confirm_debouncer_top.sv
// Flow: an accepted beat waits in the input register; as it advances it updates
//   the state and, if it confirms a flip, loads its event beat into the output register.
// Throughput: one sample beat per cycle, set by the single input register and the
//   combinational compare/update path; only flips wait on a full, stalled output.
// Reset (rst_ni low, asynchronous): block disarmed, no pending run, windows at
//   3000 ms and 300000 ms, both beat registers empty.
`default_nettype none

module presence_confirm_debouncer_top #(
  parameter int unsigned TIME_WIDTH = 40
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  pcd_sample_if.sink                       sample_i,
  pcd_event_if.source                      event_o,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [pcd_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire  [pcd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [pcd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import pcd_pkg::*;

  // Config registers.
  logic [WIN_W-1:0] arrive_win_q;
  logic [WIN_W-1:0] leave_win_q;
  cfg_reg_e         reg_sel;
  logic             cfg_wr;

  // Input register: holds one sample beat until the state logic takes it.
  logic                    in_valid_q;
  logic                    in_sv_q;
  logic                    in_pres_q;
  logic [TIME_FIELD_W-1:0] in_time_q;

  // Debounce state.
  logic                  armed_q,   armed_d;
  logic                  occ_q,     occ_d;
  logic                  first_q,   first_d;
  logic                  pend_q,    pend_d;
  logic [TIME_WIDTH-1:0] start_q,   start_d;
  logic [TIME_WIDTH-1:0] fstart_q,  fstart_d;

  // Output register.
  logic                    out_valid_q;
  logic [KIND_W-1:0]       kind_q;
  logic [TIME_FIELD_W-1:0] span_q;

  logic                  [TIME_WIDTH-1:0] now_w;
  logic                  [TIME_WIDTH-1:0] run_len;
  logic                  [TIME_WIDTH-1:0] span_w;
  logic                  [WIN_W-1:0]      window;
  logic                                   emit;
  logic                                   advance;
  event_kind_e                            kind_d;

  // ---------------------------------------------------------------------------
  // APB config port: write on the access phase, read mux by word index.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_sel)
      REG_ARRIVE: prdata = APB_DATA_W'(arrive_win_q);
      REG_LEAVE:  prdata = APB_DATA_W'(leave_win_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arrive_win_q <= ARRIVE_RESET;
      leave_win_q  <= LEAVE_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_ARRIVE: arrive_win_q <= pwdata[WIN_W-1:0];
        REG_LEAVE:  leave_win_q  <= pwdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. The held beat advances unless it carries an event and the
  // output register is still full and stalled; beats with no event never wait.
  // ---------------------------------------------------------------------------
  assign advance        = in_valid_q && (!emit || !out_valid_q || event_o.ready);
  assign sample_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (sample_i.ready) begin
      in_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i.ready && sample_i.valid) begin
      in_sv_q   <= sample_i.sample_valid;
      in_pres_q <= sample_i.present;
      in_time_q <= sample_i.time_ms;
    end
  end

  // ---------------------------------------------------------------------------
  // Debounce decision. Only the low TIME_WIDTH bits of the timestamp count;
  // elapsed time and span saturate at zero when time runs backwards.
  // ---------------------------------------------------------------------------
  assign now_w   = TIME_WIDTH'(in_time_q);
  assign run_len = (now_w >= fstart_q) ? (now_w - fstart_q) : '0;
  assign span_w  = (fstart_q >= start_q) ? (fstart_q - start_q) : '0;
  assign window  = occ_q ? leave_win_q : arrive_win_q;

  // A flip is confirmed by a later contradicting sample once the run is long enough.
  assign emit = in_sv_q && armed_q && (in_pres_q != occ_q) && pend_q
                && (run_len >= TIME_WIDTH'(window));

  always_comb begin
    if (occ_q) begin
      kind_d = EV_DEPART;
    end else if (first_q) begin
      kind_d = EV_FIRST_ARRIVE;
    end else begin
      kind_d = EV_ARRIVE;
    end
  end

  always_comb begin
    armed_d  = armed_q;
    occ_d    = occ_q;
    first_d  = first_q;
    pend_d   = pend_q;
    start_d  = start_q;
    fstart_d = fstart_q;
    if (in_sv_q) begin
      if (!armed_q) begin
        // First valid sample: take its flag as the confirmed state.
        armed_d = 1'b1;
        occ_d   = in_pres_q;
        start_d = now_w;
      end else if (in_pres_q == occ_q) begin
        // Agreeing sample: drop any contradicting run.
        pend_d = 1'b0;
      end else if (!pend_q) begin
        // Start a run, dated by this sample.
        pend_d   = 1'b1;
        fstart_d = now_w;
      end else if (emit) begin
        // Flip: the new state starts where the run started.
        occ_d    = !occ_q;
        start_d  = fstart_q;
        pend_d   = 1'b0;
        fstart_d = '0;
        first_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q  <= 1'b0;
      occ_q    <= 1'b0;
      first_q  <= 1'b1;
      pend_q   <= 1'b0;
      start_q  <= '0;
      fstart_q <= '0;
    end else if (advance) begin
      armed_q  <= armed_d;
      occ_q    <= occ_d;
      first_q  <= first_d;
      pend_q   <= pend_d;
      start_q  <= start_d;
      fstart_q <= fstart_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: load an event beat on a confirmed flip, drop it when taken.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (event_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      kind_q <= kind_d;
      span_q <= TIME_FIELD_W'(span_w);
    end
  end

  assign event_o.valid      = out_valid_q;
  assign event_o.event_kind = kind_q;
  assign event_o.span_ms    = span_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `include "presence_confirm_debouncer_top_assert.svh"

  `PCD_ASSERT_NOW(a_emit_needs_run, advance && emit, armed_q && pend_q, "event without pending run")
  `PCD_ASSERT_NEXT(a_flip_toggles, advance && emit, occ_q != $past(occ_q), "flip did not toggle")
  `PCD_ASSERT_NEXT(a_first_cleared, advance && emit, !first_q && !pend_q, "state not updated")
  `PCD_ASSERT_NOW(a_kind_legal, out_valid_q,
                  kind_q == EV_DEPART || kind_q == EV_FIRST_ARRIVE || kind_q == EV_ARRIVE,
                  "illegal event kind")

endmodule

`default_nettype wire

// File: tb/sv/pcd_event_checker.sv
module pcd_event_checker (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  pcd_sample_if                          smp,
  pcd_event_if                           evt,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [pcd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire  [pcd_pkg::APB_DATA_W-1:0] pwdata,
  input  wire  [pcd_pkg::APB_DATA_W-1:0] prdata,
  input  wire                            pready,
  output int                             fail_count_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pcd_pkg::*;

  typedef struct packed {
    event_kind_e             kind;
    logic [TIME_FIELD_W-1:0] span_ms;
  } presence_event_t;

  presence_event_t events_due[$];

  logic [WIN_W-1:0]        arrive_win;
  logic [WIN_W-1:0]        leave_win;
  logic                    armed;
  logic                    occupied;
  logic                    first_arrival;
  logic                    run_open;
  logic [TIME_FIELD_W-1:0] state_start;
  logic [TIME_FIELD_W-1:0] run_start;
  int                      fails = 0;

  // Saturate at zero when time runs backwards.
  function automatic logic [TIME_FIELD_W-1:0] elapsed_ms(
    input logic [TIME_FIELD_W-1:0] later,
    input logic [TIME_FIELD_W-1:0] earlier
  );
    return (later >= earlier) ? later - earlier : '0;
  endfunction

  task automatic debounce_sample(input logic sv, input logic pr,
                                 input logic [TIME_FIELD_W-1:0] t);
    logic [WIN_W-1:0] win;
    presence_event_t  ev;
    if (!sv) return;
    if (!armed) begin
      armed       = 1'b1;
      occupied    = pr;
      state_start = t;
      return;
    end
    if (pr == occupied) begin
      run_open = 1'b0;
      return;
    end
    if (!run_open) begin
      run_open  = 1'b1;
      run_start = t;
      return;
    end
    win = occupied ? leave_win : arrive_win;
    if (elapsed_ms(t, run_start) < TIME_FIELD_W'(win)) return;
    if (occupied) ev.kind = EV_DEPART;
    else if (first_arrival) ev.kind = EV_FIRST_ARRIVE;
    else ev.kind = EV_ARRIVE;
    ev.span_ms = elapsed_ms(run_start, state_start);
    events_due.push_back(ev);
    occupied      = ~occupied;
    state_start   = run_start;
    run_open      = 1'b0;
    run_start     = '0;
    first_arrival = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    presence_event_t want;
    logic [WIN_W-1:0] reg_val;
    if (!rst_ni) begin
      arrive_win    = ARRIVE_RESET;
      leave_win     = LEAVE_RESET;
      armed         = 1'b0;
      occupied      = 1'b0;
      first_arrival = 1'b1;
      run_open      = 1'b0;
      state_start   = '0;
      run_start     = '0;
      events_due.delete();
    end else begin
      // An event beat always belongs to an earlier sample, so match first.
      if (evt.valid && evt.ready) begin
        if (events_due.size() == 0) begin
          $error("unexpected event beat: event_kind %0d span_ms %0d",
                 evt.event_kind, evt.span_ms);
          fails++;
        end else begin
          want = events_due.pop_front();
          if (evt.event_kind !== want.kind) begin
            $error("event_kind mismatch: expected %0d actual %0d", want.kind, evt.event_kind);
            fails++;
          end
          if (evt.span_ms !== want.span_ms) begin
            $error("span_ms mismatch: expected %0d actual %0d", want.span_ms, evt.span_ms);
            fails++;
          end
        end
      end
      if (smp.valid && smp.ready) debounce_sample(smp.sample_valid, smp.present, smp.time_ms);
      if (psel && penable && pready && paddr[1:0] == 2'b00) begin
        if (pwrite) begin
          if (cfg_reg_e'(paddr[2]) == REG_ARRIVE) arrive_win = pwdata[WIN_W-1:0];
          else leave_win = pwdata[WIN_W-1:0];
        end else begin
          reg_val = (cfg_reg_e'(paddr[2]) == REG_ARRIVE) ? arrive_win : leave_win;
          if (prdata !== APB_DATA_W'(reg_val)) begin
            $error("prdata mismatch at paddr %0d: expected %0d actual %0d",
                   paddr, reg_val, prdata);
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= events_due.size();
  end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pcd_pkg::*;

  // Generous ceiling: every phase item can see a long sender gap and a long
  // receiver stall, plus the hold-off and the drains between phases.
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS     = 225;
  localparam int IDLE_PCT        = 69;
  localparam int BOTH_PCT        = 28;
  localparam logic [APB_DATA_W-1:0] HIGH_JUNK = 32'hF800_0000;

  logic clk    = 1'b0;
  logic rst_ni = 1'b0;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_reqs     = 0;
  int cycle_count   = 0;

  // Running sample timeline shared by the whole stimulus.
  logic [TIME_FIELD_W-1:0] now_ms;

  pcd_sample_if smp_if ();
  pcd_event_if  evt_if ();

  presence_confirm_debouncer_top DUT (
    .clk_i    (clk),
    .rst_ni   (rst_ni),
    .sample_i (smp_if),
    .event_o  (evt_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // The checker watches both channels and the register port on its own.
  pcd_event_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .smp          (smp_if),
    .evt          (evt_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a missing event beat ends up here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Event receiver. Stall at the current rate, or hold ready low for a long
  // stretch whenever the stimulus asks for back-pressure.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    evt_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        evt_if.ready <= 1'b0;
      end else begin
        evt_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Offer one sample beat, with a random gap first, and hold it until taken.
  // Valid is left high; the next beat or a drain decides what comes next.
  task automatic send_sample(input logic sv, input logic pr,
                             input logic [TIME_FIELD_W-1:0] t);
    while ($urandom_range(99) < src_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(posedge clk);
    end
    smp_if.valid        <= 1'b1;
    smp_if.sample_valid <= sv;
    smp_if.present      <= pr;
    smp_if.time_ms      <= t;
    @(posedge clk);
    while (!smp_if.ready) @(posedge clk);
  endtask

  // Drop valid, wait until every expected event beat is out, then let the
  // pipeline settle so a sample with no event is fully absorbed.
  task automatic drain_events();
    smp_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register access: setup phase, access phase held until pready, then idle.
  task automatic cfg_access(input logic wr, input cfg_reg_e r,
                            input logic [APB_DATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {r, 2'b00};
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write both windows and read them back; the checker compares the reads.
  task automatic set_windows(input logic [APB_DATA_W-1:0] arrive,
                             input logic [APB_DATA_W-1:0] leave);
    cfg_access(1'b1, REG_ARRIVE, arrive);
    cfg_access(1'b1, REG_LEAVE, leave);
    cfg_access(1'b0, REG_ARRIVE, '0);
    cfg_access(1'b0, REG_LEAVE, '0);
  endtask

  // Random phase: mostly presence runs of random length, each a candidate
  // flip, with contradicting noise, dropped samples, time jumps forward and
  // occasional steps backwards. Only valid samples count toward the quota.
  task automatic random_phase(input int step_max, input int src_pct,
                              input int snk_pct, input bit squeeze);
    int   sent;
    int   run_len;
    int   roll;
    logic lvl;
    logic sv;
    logic pr;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    if (squeeze) hold_reqs++;
    sent = 0;
    lvl  = 1'($urandom_range(1));
    while (sent < PHASE_ITEMS) begin
      lvl     = ~lvl;
      run_len = $urandom_range(12, 1);
      repeat (run_len) begin
        roll = $urandom_range(99);
        if (roll < 2) now_ms -= TIME_FIELD_W'($urandom_range(2 * step_max));
        else if (roll < 6) now_ms += TIME_FIELD_W'($urandom_range(32'h0FFF_FFFF));
        else now_ms += TIME_FIELD_W'($urandom_range(step_max));
        sv = ($urandom_range(99) >= 8);
        pr = ($urandom_range(99) < 8) ? ~lvl : lvl;
        if (!sv) pr = 1'($urandom_range(1));
        send_sample(sv, pr, now_ms);
        if (sv) sent++;
      end
    end
  endtask

  initial begin
    smp_if.valid        <= 1'b0;
    smp_if.sample_valid <= 1'b0;
    smp_if.present      <= 1'b0;
    smp_if.time_ms      <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    now_ms               = '0;

    repeat (10) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Check the reset windows by reading them.
    cfg_access(1'b0, REG_ARRIVE, '0);
    cfg_access(1'b0, REG_LEAVE, '0);

    // Directed walk with the reset windows (3 s arrive, 5 min leave).
    send_sample(1'b0, 1'b1, '1);              // ignored before arming
    send_sample(1'b1, 1'b0, 40'd0);           // arm as empty at time zero
    send_sample(1'b1, 1'b1, 40'd0);           // run that starts at time zero
    send_sample(1'b1, 1'b1, 40'd2999);        // one short of the window
    send_sample(1'b1, 1'b1, 40'd3000);        // first arrival, span 0
    send_sample(1'b1, 1'b0, 40'd5000);        // absence run opens
    send_sample(1'b0, 1'b1, 40'd10);          // dropped sample, no effect
    send_sample(1'b1, 1'b1, 40'd5001);        // agreeing sample cancels it
    send_sample(1'b1, 1'b0, 40'd6000);
    send_sample(1'b1, 1'b0, 40'd305999);
    send_sample(1'b1, 1'b0, 40'd306000);      // departure, span 6000
    send_sample(1'b1, 1'b1, 40'd306000);
    send_sample(1'b1, 1'b1, 40'd100);         // time backwards, elapsed clamps
    send_sample(1'b1, 1'b1, 40'd309000);      // arrival after absence
    send_sample(1'b1, 1'b0, 40'd5);           // run dated before the state start
    send_sample(1'b1, 1'b0, 40'd400005);      // departure, span clamps to zero
    send_sample(1'b1, 1'b1, '1);              // all-ones timestamps
    send_sample(1'b1, 1'b1, '1);
    send_sample(1'b1, 1'b0, '1);
    drain_events();

    // Zero windows: the opening sample only dates the run.
    set_windows('0, '0);
    random_phase(3, 0, 0, 1'b0);
    drain_events();

    set_windows(32'd20, 32'd50);
    random_phase(10, IDLE_PCT, 0, 1'b0);
    drain_events();

    // One-day windows (86400000 ms) with junk above bit 26; start near the wrap.
    now_ms = 40'hFF_FFF0_0000;
    set_windows(HIGH_JUNK | 32'd86400000, HIGH_JUNK | 32'd86400000);
    random_phase(1000, 0, IDLE_PCT, 1'b0);
    drain_events();

    // All arrive-register bits set, leave window 1, random time base.
    now_ms = {8'($urandom), 32'($urandom)};
    set_windows('1, 32'd1);
    random_phase(5000, BOTH_PCT, BOTH_PCT, 1'b0);
    drain_events();

    // Short windows with back-pressure: the receiver holds off while the
    // sender keeps offering, so the output fills and the input stalls.
    set_windows(32'd7, 32'd3);
    random_phase(4, 0, 0, 1'b1);
    drain_events();

    set_windows(32'd1, '0);
    random_phase(2, 0, IDLE_PCT, 1'b0);
    drain_events();

    set_windows(32'd100, 32'd3000);
    random_phase(500, IDLE_PCT, 0, 1'b0);
    drain_events();

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
